// ===== design/rtyuv_pkg.sv =====
// Shared types and constants for the RGB to planar YUV 4:2:0 converter.
`timescale 1ns / 1ps

package rtyuv_pkg;

	// Configuration register file
	localparam int CFG_W       = 13;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

	// Field widths
	localparam int PIX_W       = 8;
	localparam int Y_ADDR_W    = 24;
	localparam int UV_ADDR_W   = 25;
	localparam int SUM_W       = 15;   // weighted sums stay within 0..25550
	localparam int SUM_EXT_W   = 16;

	// Color weights (percent)
	localparam int YR = 30;
	localparam int YG = 59;
	localparam int YB = 11;
	localparam int UR = 17;
	localparam int UG = 33;
	localparam int UB = 50;
	localparam int VR = 50;
	localparam int VG = 42;
	localparam int VB = 8;
	localparam int CHROMA_BIAS = 12800;

	// Divide by 100 as multiply by 2^19/100 rounded up; exact for sums below 43000
	localparam int RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

endpackage

// ===== design/rtyuv_color.sv =====
// Color math: weighted sums in one stage, divide by 100 in the next.
`timescale 1ns / 1ps

module rtyuv_color (
	input  logic                      clk,
	input  logic                      en_s2,
	input  logic                      en_out,
	input  rtyuv_pkg::pixel_t         pixel_s1,
	output logic [rtyuv_pkg::PIX_W-1:0] luma_q,
	output logic [rtyuv_pkg::PIX_W-1:0] cb_q,
	output logic [rtyuv_pkg::PIX_W-1:0] cr_q
);
	import rtyuv_pkg::*;

	logic [SUM_EXT_W-1:0] y_sum, u_sum, v_sum;
	logic [SUM_W-1:0]     y_sum_s2, u_sum_s2, v_sum_s2;
	logic [PROD_W-1:0]    y_prod, u_prod, v_prod;

	// Weighted sums; chroma bias keeps both chroma sums non-negative
	always_comb begin
		y_sum = SUM_EXT_W'(YR * pixel_s1.red) + SUM_EXT_W'(YG * pixel_s1.green)
			+ SUM_EXT_W'(YB * pixel_s1.blue);
		u_sum = SUM_EXT_W'(UB * pixel_s1.blue) + SUM_EXT_W'(CHROMA_BIAS)
			- SUM_EXT_W'(UR * pixel_s1.red) - SUM_EXT_W'(UG * pixel_s1.green);
		v_sum = SUM_EXT_W'(VR * pixel_s1.red) + SUM_EXT_W'(CHROMA_BIAS)
			- SUM_EXT_W'(VG * pixel_s1.green) - SUM_EXT_W'(VB * pixel_s1.blue);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			y_sum_s2 <= y_sum[SUM_W-1:0];
			u_sum_s2 <= u_sum[SUM_W-1:0];
			v_sum_s2 <= v_sum[SUM_W-1:0];
		end
	end

	// Reciprocal multiply for the divide by 100
	always_comb begin
		y_prod = PROD_W'(y_sum_s2) * PROD_W'(RECIP_100);
		u_prod = PROD_W'(u_sum_s2) * PROD_W'(RECIP_100);
		v_prod = PROD_W'(v_sum_s2) * PROD_W'(RECIP_100);
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			luma_q <= y_prod[RECIP_SHIFT +: PIX_W];
			cb_q   <= u_prod[RECIP_SHIFT +: PIX_W];
			cr_q   <= v_prod[RECIP_SHIFT +: PIX_W];
		end
	end

endmodule

// ===== design/rgb_to_yuv420_planar_stream.sv =====
// Top level: raster counters, plane addressing and the three-stage pixel pipeline.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | tvalid / tready        | tdata[23:0] = blue, green, red
//  m_axis    | out | tvalid / tready        | tdata, tuser = chroma_write, tlast = frame_end
//  cfg       | in  | cfg_wr_en (no stall)   | cfg_index, cfg_data
//
// One pixel per cycle sustained while m_axis does not stall; a transaction is loaded into
// the input register at its accepting edge, then into the sums stage and then into the
// output register, from which it is offered on m_axis.
// Reset loads 640x480 and zeroes the raster counters; no clearing pass.
// A stall at m_axis holds the output register and backs up through the
// stages; s_axis_tready stays high while any stage has a free slot.
`timescale 1ns / 1ps

module rgb_to_yuv420_planar_stream #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: blue[7:0], green[15:8], red[23:16]
	input  logic [23:0]                         s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: luma[7:0], luma_address[31:8], chroma_blue[39:32], chroma_red[47:40],
	//        u_address[72:48], v_address[97:73], zero fill [103:98]
	output logic [103:0]                        m_axis_tdata,
	// tuser: chroma_write[0]
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_wr_en,
	input  logic [rtyuv_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rtyuv_pkg::CFG_W-1:0]         cfg_data
);
	import rtyuv_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = WW + HW;
	localparam int SW = ((PW > UV_ADDR_W) ? PW : UV_ADDR_W) + 1;

	// Effective width: even, 2..MAX_WIDTH
	function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] e;
		e = v & ~CFG_W'(1);
		if (e < CFG_W'(2))
			return WW'(2);
		else if (int'(e) > MAX_WIDTH)
			return WW'(MAX_WIDTH & ~1);
		else
			return WW'(e);
	endfunction

	// Effective height: 1..MAX_HEIGHT
	function automatic logic [HW-1:0] clamp_height(input logic [CFG_W-1:0] v);
		if (v == '0)
			return HW'(1);
		else if (int'(v) > MAX_HEIGHT)
			return HW'(MAX_HEIGHT);
		else
			return HW'(v);
	endfunction

	typedef struct packed {
		logic [Y_ADDR_W-1:0]  luma_addr;
		logic                 odd;
		logic                 frame_end;
		logic [UV_ADDR_W-1:0] chroma_off;
	} ctrl_s1_t;

	typedef struct packed {
		logic [Y_ADDR_W-1:0]  luma_addr;
		logic                 odd;
		logic                 frame_end;
		logic [UV_ADDR_W-1:0] u_addr;
		logic [UV_ADDR_W-1:0] v_addr;
	} ctrl_s2_t;

	logic [WW-1:0]        eff_w_q;
	logic [HW-1:0]        eff_h_q;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [Y_ADDR_W-1:0]  luma_ptr_q;
	logic [UV_ADDR_W-1:0] chroma_base_q;

	logic                 v_s1, v_s2, out_valid_q;
	logic                 adv_s1, adv_s2, adv_out, in_xact;
	pixel_t               pixel_s1;
	ctrl_s1_t             ctrl_s1;
	ctrl_s2_t             ctrl_s2;

	logic [CW:0]          col_inc;
	logic [RW:0]          row_inc;
	logic                 last_col, last_row;

	logic [PW-1:0]        plane;
	logic [SW-1:0]        u_full, v_full;

	logic [PIX_W-1:0]     luma_q, cb_q, cr_q;
	logic                 odd_q, frame_end_q;
	logic [Y_ADDR_W-1:0]  luma_addr_q;
	logic [UV_ADDR_W-1:0] u_addr_q, v_addr_q;

	// Pipeline flow: a stage moves when the next one is free or moving
	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv_s2        = !v_s2 || adv_out;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_xact       = s_axis_tvalid && adv_s1;

	// Configuration, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= clamp_width(FRAME_WIDTH_RESET);
			eff_h_q <= clamp_height(FRAME_HEIGHT_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  eff_w_q <= clamp_width(cfg_data);
				REG_FRAME_HEIGHT: eff_h_q <= clamp_height(cfg_data);
				default: ;
			endcase
		end
	end

	// Raster position of the pixel now at the input
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign last_col = col_inc >= (CW+1)'(eff_w_q);
	assign last_row = row_inc >= (RW+1)'(eff_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			luma_ptr_q    <= '0;
			chroma_base_q <= '0;
		end else if (in_xact) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q         <= '0;
					luma_ptr_q    <= '0;
					chroma_base_q <= '0;
				end else begin
					if (row_q[0])
						chroma_base_q <= chroma_base_q + UV_ADDR_W'(eff_w_q >> 1);
					row_q      <= row_inc[RW-1:0];
					luma_ptr_q <= luma_ptr_q + 1'b1;
				end
			end else begin
				col_q      <= col_inc[CW-1:0];
				luma_ptr_q <= luma_ptr_q + 1'b1;
			end
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv_s1)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_xact) begin
			pixel_s1.blue        <= s_axis_tdata[7:0];
			pixel_s1.green       <= s_axis_tdata[15:8];
			pixel_s1.red         <= s_axis_tdata[23:16];
			ctrl_s1.luma_addr    <= luma_ptr_q;
			ctrl_s1.odd          <= col_q[0];
			ctrl_s1.frame_end    <= last_col && last_row;
			ctrl_s1.chroma_off   <= chroma_base_q + UV_ADDR_W'(col_q >> 1);
		end
	end

	// Stage 2: chroma plane addresses (U plane after Y, V plane after U)
	assign plane  = PW'(eff_w_q) * PW'(eff_h_q);
	assign u_full = SW'(plane) + SW'(ctrl_s1.chroma_off);
	assign v_full = SW'(plane) + SW'(plane >> 2) + SW'(ctrl_s1.chroma_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ctrl_s2.luma_addr <= ctrl_s1.luma_addr;
			ctrl_s2.odd       <= ctrl_s1.odd;
			ctrl_s2.frame_end <= ctrl_s1.frame_end;
			ctrl_s2.u_addr    <= u_full[UV_ADDR_W-1:0];
			ctrl_s2.v_addr    <= v_full[UV_ADDR_W-1:0];
		end
	end

	rtyuv_color u_color (
		.clk      (clk),
		.en_s2    (adv_s2),
		.en_out   (adv_out),
		.pixel_s1 (pixel_s1),
		.luma_q   (luma_q),
		.cb_q     (cb_q),
		.cr_q     (cr_q)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_out)
			out_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			luma_addr_q <= ctrl_s2.luma_addr;
			odd_q       <= ctrl_s2.odd;
			frame_end_q <= ctrl_s2.frame_end;
			u_addr_q    <= ctrl_s2.odd ? ctrl_s2.u_addr : '0;
			v_addr_q    <= ctrl_s2.odd ? ctrl_s2.v_addr : '0;
		end
	end

	// Chroma reads as zero on even columns
	assign m_axis_tdata  = {6'd0, v_addr_q, u_addr_q,
		odd_q ? cr_q : '0, odd_q ? cb_q : '0, luma_addr_q, luma_q};
	assign m_axis_tuser  = odd_q;
	assign m_axis_tlast  = frame_end_q;
	assign m_axis_tvalid = out_valid_q;

endmodule
